@@ hw/rtl/rv32fd_pkg.sv @@
`default_nettype none

package rv32fd_pkg;

  typedef enum logic [2:0] {
    FMT_NONE = 3'd0,
    FMT_U    = 3'd1,
    FMT_J    = 3'd2,
    FMT_R    = 3'd3,
    FMT_I    = 3'd4,
    FMT_S    = 3'd5,
    FMT_B    = 3'd6
  } fmt_e;

  localparam logic [6:0] OPC_U_MASK = 7'h14;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  // rd of x0 on a writing format is reported as this value
  localparam logic [5:0] RD_ZERO_CODE = 6'd32;

  typedef struct packed {
    fmt_e        fmt;
    logic [6:0]  opcode;
    logic [5:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [2:0]  func3;
    logic [6:0]  func7;
    logic [31:0] immediate;
  } decode_t;

  function automatic decode_t decode(input logic [31:0] w);
    decode_t    r;
    logic [5:0] rd;
    logic [6:0] op;
    op = w[6:0];
    rd = (w[11:7] == 5'd0) ? RD_ZERO_CODE : {1'b0, w[11:7]};
    r  = '0;
    r.fmt    = FMT_NONE;
    r.opcode = op;
    if ((op & OPC_U_MASK) == OPC_U_MASK) begin
      r.fmt       = FMT_U;
      r.dest_reg  = rd;
      r.immediate = {{12{w[31]}}, w[31:12]};
    end else if (op == OPC_JAL) begin
      r.fmt       = FMT_J;
      r.dest_reg  = rd;
      // jump offset without its always-zero low bit
      r.immediate = {{12{w[31]}}, w[31], w[19:12], w[20], w[30:21]};
    end else if (op == OPC_OP) begin
      r.fmt      = FMT_R;
      r.dest_reg = rd;
      r.src1_reg = w[19:15];
      r.src2_reg = w[24:20];
      r.func3    = w[14:12];
      r.func7    = w[31:25];
    end else if (op == OPC_LOAD || op == OPC_OP_IMM || op == OPC_SYSTEM ||
                 op == OPC_JALR) begin
      r.fmt       = FMT_I;
      r.dest_reg  = rd;
      r.src1_reg  = w[19:15];
      r.func3     = w[14:12];
      r.immediate = {{20{w[31]}}, w[31:20]};
    end else if (op == OPC_STORE) begin
      r.fmt       = FMT_S;
      r.src1_reg  = w[19:15];
      r.src2_reg  = w[24:20];
      r.func3     = w[14:12];
      r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
    end else if (op == OPC_BRANCH) begin
      r.fmt       = FMT_B;
      r.src1_reg  = w[19:15];
      r.src2_reg  = w[24:20];
      r.func3     = w[14:12];
      r.immediate = {{20{w[31]}}, w[31], w[7], w[30:25], w[11:8]};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rv32i_field_decoder_core.sv @@
`default_nettype none

// RV32I field decoder. Each instruction word beat yields one result beat
// carrying format, opcode, register numbers, funct3/funct7 and the
// sign-extended immediate (J and B offsets are given halved, U is the upper
// 20 bits shifted down). Throughput is one instruction per clock while the
// output is not stalled. The word is held in the input register and decoded
// combinationally into the result register, which drives the outputs. A
// waiting result does not block intake while the input register is free.
module rv32i_field_decoder_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire logic [31:0]        instruction_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      logic [2:0]         format_o,
  output      logic [6:0]         opcode_o,
  output      logic [5:0]         dest_reg_o,
  output      logic [4:0]         src1_reg_o,
  output      logic [4:0]         src2_reg_o,
  output      logic [2:0]         func3_o,
  output      logic [6:0]         func7_o,
  output      logic signed [31:0] immediate_o
);

  logic                 in_valid_q;
  logic [31:0]          instr_q;
  logic                 res_valid_q;
  rv32fd_pkg::decode_t  res_q;
  rv32fd_pkg::decode_t  res_d;
  logic                 res_load;
  logic                 in_load;

  // result register takes a new beat when empty or being drained
  assign res_load   = !res_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !res_load;
  assign in_load    = in_valid_i && !in_stall_o;

  assign res_d = rv32fd_pkg::decode(instr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid_q <= in_valid_q;
      end
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (res_load) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      instr_q <= instruction_i;
    end
    if (res_load && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign format_o    = res_q.fmt;
  assign opcode_o    = res_q.opcode;
  assign dest_reg_o  = res_q.dest_reg;
  assign src1_reg_o  = res_q.src1_reg;
  assign src2_reg_o  = res_q.src2_reg;
  assign func3_o     = res_q.func3;
  assign func7_o     = res_q.func7;
  assign immediate_o = res_q.immediate;

endmodule

`default_nettype wire

@@ hw/rtl/rv32fd_checker.sv @@
`default_nettype none

module rv32fd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [2:0]         format_o,
  input wire logic [6:0]         opcode_o,
  input wire logic [5:0]         dest_reg_o,
  input wire logic [4:0]         src1_reg_o,
  input wire logic [4:0]         src2_reg_o,
  input wire logic [2:0]         func3_o,
  input wire logic [6:0]         func7_o,
  input wire logic signed [31:0] immediate_o
);

  // stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(format_o) &&
      $stable(opcode_o) && $stable(dest_reg_o) && $stable(immediate_o))
    else $error("stalled result beat changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && format_o == rv32fd_pkg::FMT_NONE |->
      dest_reg_o == 6'd0 && src1_reg_o == 5'd0 && src2_reg_o == 5'd0 &&
      func3_o == 3'd0 && func7_o == 7'd0 && immediate_o == 32'sd0)
    else $error("unknown opcode with nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (format_o == rv32fd_pkg::FMT_S || format_o == rv32fd_pkg::FMT_B)
      |-> dest_reg_o == 6'd0 && func7_o == 7'd0)
    else $error("store/branch reports a destination or funct7");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (format_o == rv32fd_pkg::FMT_U || format_o == rv32fd_pkg::FMT_J ||
      format_o == rv32fd_pkg::FMT_R || format_o == rv32fd_pkg::FMT_I)
      |-> dest_reg_o != 6'd0 && dest_reg_o <= rv32fd_pkg::RD_ZERO_CODE)
    else $error("writing format with bad destination code");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && format_o == rv32fd_pkg::FMT_U |-> opcode_o[4] && opcode_o[2])
    else $error("U format on opcode without bits 4 and 2");

endmodule

bind rv32i_field_decoder_core rv32fd_checker u_rv32fd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .format_o    (format_o),
  .opcode_o    (opcode_o),
  .dest_reg_o  (dest_reg_o),
  .src1_reg_o  (src1_reg_o),
  .src2_reg_o  (src2_reg_o),
  .func3_o     (func3_o),
  .func7_o     (func7_o),
  .immediate_o (immediate_o)
);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;

  localparam logic [6:0] OPC_LUI   = 7'h37;
  localparam logic [6:0] OPC_AUIPC = 7'h17;
  localparam int N_RANDOM   = 1300;
  localparam int PAUSE_AT   = 600;
  localparam int QUIET_AT   = 1100;
  localparam int IDLE_LIMIT = 2000;

  localparam int N_DIRECTED = 25;
  localparam logic [31:0] DIRECTED [N_DIRECTED] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0037, 32'hFFFF_F0B7, 32'h8000_0017,
    32'h0000_0014, 32'h7FFF_FFEF, 32'h8000_006F, 32'h0000_006F, 32'hFFFF_FFB3,
    32'h0000_0033, 32'h0000_0003, 32'hFFFF_FF83, 32'h8000_0013, 32'h7FF0_0073,
    32'hFFFF_FFE7, 32'hFFFF_FFA3, 32'h0000_0023, 32'h7E00_0FA3, 32'hFFFF_FFE3,
    32'h0000_0063, 32'h8000_0063, 32'h7E00_0FE3, 32'hFFFF_FF8B, 32'h0000_006B
  };

  typedef struct {
    rv32fd_pkg::fmt_e fmt;
    logic [6:0]  opcode;
    logic [5:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [2:0]  func3;
    logic [6:0]  func7;
    logic [31:0] imm;
  } dec_beat_t;

  class decode_scoreboard;
    dec_beat_t expq[$];
    int errors;
    int words;
    int checked;
    int fmt_seen[7];

    function dec_beat_t predict_fields(logic [31:0] w);
      dec_beat_t  p;
      logic [6:0] op;
      logic [5:0] rd;
      op = w[6:0];
      rd = (w[11:7] == 5'd0) ? rv32fd_pkg::RD_ZERO_CODE : {1'b0, w[11:7]};
      p = '{rv32fd_pkg::FMT_NONE, op, '0, '0, '0, '0, '0, '0};
      if ((op & rv32fd_pkg::OPC_U_MASK) == rv32fd_pkg::OPC_U_MASK) begin
        // any opcode with both bits set decodes as U, ahead of the rest
        p.fmt = rv32fd_pkg::FMT_U;
        p.dest_reg = rd;
        p.imm = {{12{w[31]}}, w[31:12]};
      end else begin
        case (op)
          rv32fd_pkg::OPC_JAL: begin
            p.fmt = rv32fd_pkg::FMT_J;
            p.dest_reg = rd;
            p.imm[9:0] = w[30:21];
            p.imm[10] = w[20];
            p.imm[18:11] = w[19:12];
            p.imm[31:19] = {13{w[31]}};
          end
          rv32fd_pkg::OPC_OP: begin
            p.fmt = rv32fd_pkg::FMT_R;
            p.dest_reg = rd;
            p.src1_reg = w[19:15];
            p.src2_reg = w[24:20];
            p.func3 = w[14:12];
            p.func7 = w[31:25];
          end
          rv32fd_pkg::OPC_LOAD, rv32fd_pkg::OPC_OP_IMM, rv32fd_pkg::OPC_SYSTEM,
          rv32fd_pkg::OPC_JALR: begin
            p.fmt = rv32fd_pkg::FMT_I;
            p.dest_reg = rd;
            p.src1_reg = w[19:15];
            p.func3 = w[14:12];
            p.imm = {{20{w[31]}}, w[31:20]};
          end
          rv32fd_pkg::OPC_STORE: begin
            p.fmt = rv32fd_pkg::FMT_S;
            p.src1_reg = w[19:15];
            p.src2_reg = w[24:20];
            p.func3 = w[14:12];
            p.imm[4:0] = w[11:7];
            p.imm[31:5] = {{20{w[31]}}, w[31:25]};
          end
          rv32fd_pkg::OPC_BRANCH: begin
            p.fmt = rv32fd_pkg::FMT_B;
            p.src1_reg = w[19:15];
            p.src2_reg = w[24:20];
            p.func3 = w[14:12];
            p.imm[3:0] = w[11:8];
            p.imm[9:4] = w[30:25];
            p.imm[10] = w[7];
            p.imm[31:11] = {21{w[31]}};
          end
          default: ;
        endcase
      end
      return p;
    endfunction

    function void note_word(logic [31:0] w);
      dec_beat_t p;
      p = predict_fields(w);
      expq.push_back(p);
      fmt_seen[p.fmt]++;
      words++;
    endfunction

    function void cmp_field(string name, logic [31:0] e, logic [31:0] g);
      if (e !== g) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, g);
        errors++;
      end
    endfunction

    function void check_beat(dec_beat_t got);
      dec_beat_t e;
      if (expq.size() == 0) begin
        $error("result beat with no pending instruction word");
        errors++;
        return;
      end
      e = expq.pop_front();
      checked++;
      cmp_field("format", e.fmt, got.fmt);
      cmp_field("opcode", e.opcode, got.opcode);
      cmp_field("dest_reg", e.dest_reg, got.dest_reg);
      cmp_field("src1_reg", e.src1_reg, got.src1_reg);
      cmp_field("src2_reg", e.src2_reg, got.src2_reg);
      cmp_field("func3", e.func3, got.func3);
      cmp_field("func7", e.func7, got.func7);
      cmp_field("immediate", e.imm, got.imm);
    endfunction

    function int pending();
      return expq.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [31:0]        instruction_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         format_o;
  logic [6:0]         opcode_o;
  logic [5:0]         dest_reg_o;
  logic [4:0]         src1_reg_o;
  logic [4:0]         src2_reg_o;
  logic [2:0]         func3_o;
  logic [6:0]         func7_o;
  logic signed [31:0] immediate_o;

  decode_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;

  rv32i_field_decoder_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .instruction_i(instruction_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .format_o     (format_o),
    .opcode_o     (opcode_o),
    .dest_reg_o   (dest_reg_o),
    .src1_reg_o   (src1_reg_o),
    .src2_reg_o   (src2_reg_o),
    .func3_o      (func3_o),
    .func7_o      (func7_o),
    .immediate_o  (immediate_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
  endfunction

  // mostly legal opcodes with random upper bits, the rest raw noise words
  function automatic logic [31:0] rand_word();
    logic [6:0]  legal_ops [10];
    logic [31:0] w;
    legal_ops = '{OPC_LUI, OPC_AUIPC, rv32fd_pkg::OPC_JAL, rv32fd_pkg::OPC_OP,
                  rv32fd_pkg::OPC_LOAD, rv32fd_pkg::OPC_OP_IMM, rv32fd_pkg::OPC_SYSTEM,
                  rv32fd_pkg::OPC_JALR, rv32fd_pkg::OPC_STORE, rv32fd_pkg::OPC_BRANCH};
    w = $urandom();
    if ($urandom_range(0, 3) != 0) w[6:0] = legal_ops[$urandom_range(0, 9)];
    return w;
  endfunction

  // drive one beat, hold it until taken, then optionally go idle
  task automatic send_word(input logic [31:0] w, input int gap);
    in_valid_i <= 1'b1;
    instruction_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(w);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      instruction_i <= $urandom();
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // result side: check taken beats, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_beat('{rv32fd_pkg::fmt_e'(format_o), opcode_o, dest_reg_o, src1_reg_o,
                      src2_reg_o, func3_o, func7_o, immediate_o});
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && rst_ni && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 11);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_word(DIRECTED[i], (i == N_DIRECTED - 1) ? 1 : pick_gap());
    end
    drain_results();

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == QUIET_AT) quiet = 1'b1;
      send_word(rand_word(), (n == PAUSE_AT - 1) ? 1 : pick_gap());
      if (n == PAUSE_AT - 1) drain_results();
    end
    in_valid_i <= 1'b0;

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("decoded %0d instruction words, checked %0d result beats", sb.words, sb.checked);
    $display("by format none/U/J/R/I/S/B: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
             sb.fmt_seen[0], sb.fmt_seen[1], sb.fmt_seen[2], sb.fmt_seen[3],
             sb.fmt_seen[4], sb.fmt_seen[5], sb.fmt_seen[6]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/rv32fd_pkg.sv
hw/rtl/rv32i_field_decoder_core.sv
hw/rtl/rv32fd_checker.sv
verif/tb.sv
